// File: rtl/core/arp_pkg.sv
// Shared types and constants for the ARP cache and responder.
// Used by the table RAM users, the top level and the port checker.
// No dependencies.
package arp_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Packet constants
   localparam logic [15:0] PTYPE_IP       = 16'h0800;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

   // Operation selector carried in req_tuser
   typedef enum logic [1:0] {
      OP_RX_PACKET = 2'd0,
      OP_LOOKUP    = 2'd1,
      OP_REQ_SENT  = 2'd2
   } op_type;

   // Result status carried in rsp_tuser
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NOT_IPV4 = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // Per-entry binding state
   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_PENDING  = 2'd1,
      SLOT_RESOLVED = 2'd2
   } slot_state_type;

   // One table entry as stored in the RAM
   typedef struct packed {
      slot_state_type state;
      logic [31:0]    ip;
      logic [47:0]    mac;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Control sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_FINISH
   } fsm_type;

   // Request word layout, lowest field last
   typedef struct packed {
      logic [6:0]  pad;
      logic        lookup_is_ether;
      logic [31:0] target_ip;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [15:0] proto_type;
      logic [15:0] hw_type;
      logic [15:0] arp_op;
   } req_item_type;

   // Response word layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] reply_src_ip;
      logic [31:0] reply_dest_ip;
      logic [47:0] reply_dest_mac;
      logic        send_reply;
      logic        entry_added;
      logic        entry_updated;
      logic [47:0] found_mac;
      logic        hit;
   } rsp_item_type;

   localparam int REQ_TDATA_W = $bits(req_item_type);
   localparam int RSP_TDATA_W = $bits(rsp_item_type);
   localparam int USER_W      = 2;

endpackage

// File: rtl/core/arp_table_ram.sv
// Simple dual-port synchronous RAM holding the ARP table entries.
// One write port, one read port with registered read data. No package use.
module arp_table_ram #(
   parameter int DATA_W = 82,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/arp_cache_and_responder.sv
// ARP cache with responder: top level, sequencer and result register.
// Depends on arp_pkg and arp_table_ram.
//
// One word is handled at a time. A received IPv4 packet or an Ethernet lookup
// walks the table entries in order through the RAM read port, one entry per
// cycle behind the registered read data, and stops at the first match; the
// next word can be accepted in the cycle after the result is loaded. A
// request-sent append goes through the append state to the result load; an
// ignored packet, a non-Ethernet lookup and an unused operation go straight
// to the result load. The result sits in an output register, so the next
// word is accepted while an earlier result still waits to be taken; a
// finished word holds the sequencer until that register frees up. All table
// writes (update or append) happen at the end of a walk or in the append
// state, before the next word can start reading, so no access to an entry
// can overlap another. The table needs no clearing after reset: only entries
// below the fill count are ever read.
module arp_cache_and_responder
   import arp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // arp_op[15:0], hw_type[31:16], proto_type[47:32], sender_mac[95:48],
   // sender_ip[127:96], target_ip[159:128], lookup_is_ether[160], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [USER_W-1:0]      req_tuser,
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // hit[0], found_mac[48:1], entry_updated[49], entry_added[50],
   // send_reply[51], reply_dest_mac[99:52], reply_dest_ip[131:100],
   // reply_src_ip[163:132], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [USER_W-1:0]      rsp_tuser,
   // Own address register
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata
);

   req_item_type   req_item;
   fsm_type        state_ff, state_in;

   // Captured request
   logic [1:0]     op_ff;
   logic           proto_ok_ff;
   logic           is_req_ff;
   logic           ether_ff;
   logic [47:0]    smac_ff;
   logic [31:0]    sip_ff;
   logic [31:0]    tip_ff;

   logic [31:0]    own_ipv4_ff;
   logic [CNT_W-1:0] fill_ff;

   // Walk state
   logic [CNT_W-1:0] rd_idx_ff;
   logic           rd_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic           found_ff;
   logic [47:0]    found_mac_ff;
   logic           added_ff;
   logic           full_ff;

   // Result register
   logic           rsp_vld_ff;
   rsp_item_type   rsp_data_ff;
   status_type     rsp_status_ff;

   // Combinational
   logic           accept;
   logic           issue;
   logic           match;
   logic           scan_miss;
   logic           tip_ours;
   logic           table_full;
   logic           append_try;
   logic           load_rsp;
   logic           ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   slot_entry_type ram_wr_entry;
   logic [ENTRY_W-1:0] ram_rd_data;
   slot_entry_type rd_entry;
   rsp_item_type   res_item;
   status_type     res_status;
   logic           rx_ok;

   assign req_item   = req_item_type'(req_tdata);
   assign rd_entry   = slot_entry_type'(ram_rd_data);
   assign tip_ours   = (tip_ff == own_ipv4_ff);
   assign table_full = (fill_ff >= CNT_W'(TABLE_ENTRIES));
   assign rx_ok      = (op_ff == OP_RX_PACKET) && proto_ok_ff;

   // Compare the entry returned by the RAM against the captured key
   always_comb begin
      match = 1'b0;
      if (rd_vld_ff) begin
         if (op_ff == OP_LOOKUP) begin
            match = (rd_entry.ip == tip_ff) && (rd_entry.state == SLOT_RESOLVED);
         end else begin
            match = (rd_entry.ip == sip_ff);
         end
      end
   end

   assign scan_miss = !match && (rd_idx_ff >= fill_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  OP_RX_PACKET: begin
                     state_in = (req_item.proto_type == PTYPE_IP) ? ST_SCAN : ST_FINISH;
                  end
                  OP_LOOKUP: begin
                     state_in = req_item.lookup_is_ether ? ST_SCAN : ST_FINISH;
                  end
                  OP_REQ_SENT: begin
                     state_in = ST_APPEND;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (match || scan_miss) begin
               state_in = ST_FINISH;
            end
         end
         ST_APPEND: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake, RAM read and write
   always_comb begin
      req_tready   = 1'b0;
      issue        = 1'b0;
      append_try   = 1'b0;
      load_rsp     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_ff[IDX_W-1:0];
      ram_wr_entry = '{state: SLOT_RESOLVED, ip: sip_ff, mac: smac_ff};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            // stop reading once an entry matches
            issue = (rd_idx_ff < fill_ff) && !match;
            if (match && (op_ff == OP_RX_PACKET)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cmp_idx_ff;
            end else if (scan_miss && (op_ff == OP_RX_PACKET) && tip_ours) begin
               append_try = 1'b1;
               ram_wr_en  = !table_full;
            end
         end
         ST_APPEND: begin
            append_try   = 1'b1;
            ram_wr_en    = !table_full;
            ram_wr_entry = '{state: SLOT_PENDING, ip: tip_ff, mac: 48'd0};
         end
         ST_FINISH: begin
            load_rsp = !rsp_vld_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Build the result from the captured word and walk flags
   always_comb begin
      res_item                = '0;
      res_item.hit            = (op_ff == OP_LOOKUP) && found_ff;
      res_item.found_mac      = res_item.hit ? found_mac_ff : 48'd0;
      res_item.entry_updated  = rx_ok && found_ff;
      res_item.entry_added    = added_ff;
      res_item.send_reply     = rx_ok && is_req_ff && tip_ours;
      if (res_item.send_reply) begin
         res_item.reply_dest_mac = smac_ff;
         res_item.reply_dest_ip  = sip_ff;
         res_item.reply_src_ip   = own_ipv4_ff;
      end
      if ((op_ff == OP_RX_PACKET) && !proto_ok_ff) begin
         res_status = STATUS_NOT_IPV4;
      end else if (full_ff) begin
         res_status = STATUS_FULL;
      end else begin
         res_status = STATUS_DONE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         own_ipv4_ff <= 32'd0;
         fill_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            own_ipv4_ff <= csr_wdata;
         end
         if (append_try && !table_full) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         rd_vld_ff <= issue;
         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Capture the word, walk the table, record flags
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser;
         proto_ok_ff <= (req_item.proto_type == PTYPE_IP);
         is_req_ff   <= (req_item.arp_op == OPCODE_REQUEST);
         ether_ff    <= req_item.lookup_is_ether;
         smac_ff     <= req_item.sender_mac;
         sip_ff      <= req_item.sender_ip;
         tip_ff      <= req_item.target_ip;
         rd_idx_ff   <= '0;
         found_ff    <= 1'b0;
         added_ff    <= 1'b0;
         full_ff     <= 1'b0;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         if (match) begin
            found_ff     <= 1'b1;
            found_mac_ff <= rd_entry.mac;
         end
         if (append_try) begin
            added_ff <= !table_full;
            full_ff  <= table_full;
         end
      end
      cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
      if (load_rsp) begin
         rsp_data_ff   <= res_item;
         rsp_status_ff <= res_status;
      end
   end

   // Lookups that are not for Ethernet never enter the walk
   logic lookup_walk_ok;
   assign lookup_walk_ok = ether_ff || (op_ff != OP_LOOKUP);

   arp_table_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (issue && lookup_walk_ok),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/core/arp_checker.sv
// Port-level checker for the ARP cache and responder, bound to the top level.
// Depends on arp_pkg.
module arp_checker
   import arp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [USER_W-1:0]      rsp_tuser
);

   rsp_item_type rsp_item;
   assign rsp_item = rsp_item_type'(rsp_tdata);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A lookup hit carries no packet-side effects
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.hit |->
         !rsp_item.entry_updated && !rsp_item.entry_added && !rsp_item.send_reply &&
         (rsp_tuser == STATUS_DONE))
      else $error("lookup hit mixed with packet results");

   // Without a reply the reply fields stay zero
   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item.send_reply |->
         (rsp_item.reply_dest_mac == 48'd0) && (rsp_item.reply_dest_ip == 32'd0) &&
         (rsp_item.reply_src_ip == 32'd0))
      else $error("reply fields set without send_reply");

   // A miss reports a zero address, and a dropped append adds nothing
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (!rsp_item.hit || (rsp_tuser == STATUS_FULL)) |->
         (rsp_item.hit || (rsp_item.found_mac == 48'd0)) &&
         ((rsp_tuser != STATUS_FULL) || !rsp_item.entry_added))
      else $error("miss with address or dropped append marked added");

endmodule

bind arp_cache_and_responder arp_checker u_arp_checker (.*);

// File: verif/arp_reply_checker.sv
// Response checker for the ARP cache and responder: predicts each response
// word from the accepted request words and compares it field by field.
// Depends on arp_pkg.
`timescale 1ns / 1ps
module arp_reply_checker
   import arp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [USER_W-1:0]      req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [USER_W-1:0]      rsp_tuser,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   output int                     error_count,
   output int                     outstanding
);

   localparam int PRINT_CAP = 200;

   typedef struct {
      status_type   status;
      rsp_item_type word;
   } arp_reply_type;

   // Shadow copy of the binding table and the own address
   slot_state_type tbl_state [TABLE_ENTRIES];
   logic [31:0]    tbl_ip    [TABLE_ENTRIES];
   logic [47:0]    tbl_mac   [TABLE_ENTRIES];
   int             tbl_fill;
   logic [31:0]    own_ip;

   // Replies predicted and not yet seen on the response channel
   arp_reply_type  pending_replies [$];

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t arp check: %s got %h want %h", $time, field, got, want);
      error_count++;
   endtask

   // Append an entry at the fill point; refuse when the table is full
   task automatic table_append(input slot_state_type st, input logic [31:0] ip,
                               input logic [47:0] mac, output bit ok);
      ok = (tbl_fill < TABLE_ENTRIES);
      if (ok) begin
         tbl_state[tbl_fill] = st;
         tbl_ip[tbl_fill]    = ip;
         tbl_mac[tbl_fill]   = mac;
         tbl_fill++;
      end
   endtask

   // Apply one request word to the shadow table and build its reply
   task automatic arp_table_step(input logic [1:0] op, input req_item_type w,
                                 output arp_reply_type r);
      int i;
      bit found;
      bit ok;
      r.status = STATUS_DONE;
      r.word   = '0;
      found    = 1'b0;
      case (op)
         OP_RX_PACKET: begin
            if (w.proto_type != PTYPE_IP) begin
               r.status = STATUS_NOT_IPV4;
            end else begin
               for (i = 0; i < tbl_fill && !found; i++) begin
                  if (tbl_ip[i] == w.sender_ip) begin
                     tbl_mac[i]   = w.sender_mac;
                     tbl_state[i] = SLOT_RESOLVED;
                     found        = 1'b1;
                  end
               end
               if (found) begin
                  r.word.entry_updated = 1'b1;
               end else if (w.target_ip == own_ip) begin
                  table_append(SLOT_RESOLVED, w.sender_ip, w.sender_mac, ok);
                  if (ok) r.word.entry_added = 1'b1;
                  else r.status = STATUS_FULL;
               end
               // answer requests aimed at us, even when the table is full
               if (w.arp_op == OPCODE_REQUEST && w.target_ip == own_ip) begin
                  r.word.send_reply     = 1'b1;
                  r.word.reply_dest_mac = w.sender_mac;
                  r.word.reply_dest_ip  = w.sender_ip;
                  r.word.reply_src_ip   = own_ip;
               end
            end
         end
         OP_LOOKUP: begin
            if (w.lookup_is_ether) begin
               for (i = 0; i < tbl_fill && !found; i++) begin
                  if (tbl_ip[i] == w.target_ip && tbl_state[i] == SLOT_RESOLVED) begin
                     r.word.hit       = 1'b1;
                     r.word.found_mac = tbl_mac[i];
                     found            = 1'b1;
                  end
               end
            end
         end
         OP_REQ_SENT: begin
            table_append(SLOT_PENDING, w.target_ip, 48'h0, ok);
            if (ok) r.word.entry_added = 1'b1;
            else r.status = STATUS_FULL;
         end
         default: ;
      endcase
   endtask

   task automatic check_reply(input arp_reply_type want);
      rsp_item_type got;
      got = rsp_tdata;
      if (rsp_tuser !== want.status)
         report_mismatch("status", rsp_tuser, want.status);
      if (got.hit !== want.word.hit)
         report_mismatch("hit", got.hit, want.word.hit);
      if (got.found_mac !== want.word.found_mac)
         report_mismatch("found_mac", got.found_mac, want.word.found_mac);
      if (got.entry_updated !== want.word.entry_updated)
         report_mismatch("entry_updated", got.entry_updated, want.word.entry_updated);
      if (got.entry_added !== want.word.entry_added)
         report_mismatch("entry_added", got.entry_added, want.word.entry_added);
      if (got.send_reply !== want.word.send_reply)
         report_mismatch("send_reply", got.send_reply, want.word.send_reply);
      if (got.reply_dest_mac !== want.word.reply_dest_mac)
         report_mismatch("reply_dest_mac", got.reply_dest_mac, want.word.reply_dest_mac);
      if (got.reply_dest_ip !== want.word.reply_dest_ip)
         report_mismatch("reply_dest_ip", got.reply_dest_ip, want.word.reply_dest_ip);
      if (got.reply_src_ip !== want.word.reply_src_ip)
         report_mismatch("reply_src_ip", got.reply_src_ip, want.word.reply_src_ip);
   endtask

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin : watch
      arp_reply_type r;
      if (reset) begin
         tbl_fill    = 0;
         own_ip      = 32'h0;
         error_count = 0;
         pending_replies.delete();
         for (int i = 0; i < TABLE_ENTRIES; i++) tbl_state[i] = SLOT_EMPTY;
      end else begin
         // a response always belongs to a word accepted earlier: check it first
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("word with none pending", rsp_tdata[63:0], 64'h0);
            end else begin
               r = pending_replies.pop_front();
               check_reply(r);
            end
         end
         if (csr_we) own_ip = csr_wdata;
         if (req_tvalid && req_tready === 1'b1) begin
            arp_table_step(req_tuser, req_tdata, r);
            pending_replies.push_back(r);
         end
      end
      outstanding <= pending_replies.size();
   end

endmodule

// File: verif/tb_arp_cache_and_responder.sv
// Testbench top for the ARP cache and responder: clock, reset, request and
// register stimulus, random response back-pressure and the final verdict.
// Depends on arp_pkg, arp_cache_and_responder and arp_reply_checker.
`timescale 1ns / 1ps
module tb_arp_cache_and_responder;
   import arp_pkg::*;

   localparam int          RANDOM_WORDS = 1325;
   localparam int          PHASES       = 5;
   localparam int          SETTLE       = 24;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          POOL_SIZE    = 16;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [15:0] OPCODE_REPLY = 16'h0002;
   localparam logic [15:0] HW_ETHER     = 16'h0001;
   localparam logic [15:0] PROTO_IPV6   = 16'h86DD;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [USER_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [USER_W-1:0]      rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [31:0]            csr_wdata  = '0;

   int          errors;
   int          outstanding;
   int          cycles = 0;
   bit          quiet  = 1'b0;
   logic [31:0] own_addr;
   logic [31:0] ip_pool [POOL_SIZE];

   arp_cache_and_responder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   arp_reply_checker u_reply_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (errors),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_arp_cache_and_responder: done, errors");
         $finish;
      end
   end

   // Stall the response side with a chance of 30 in 100, never while quiet
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 30);
   end

   function automatic req_item_type make_word(
      logic [15:0] opcode, logic [15:0] hw, logic [15:0] proto,
      logic [47:0] mac, logic [31:0] sip, logic [31:0] tip, logic ether);
      req_item_type w;
      w                 = '0;
      w.arp_op          = opcode;
      w.hw_type         = hw;
      w.proto_type      = proto;
      w.sender_mac      = mac;
      w.sender_ip       = sip;
      w.target_ip       = tip;
      w.lookup_is_ether = ether;
      return w;
   endfunction

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 99) < 70) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Offer one word, with random idle cycles ahead of it; return at a falling edge
   task automatic send_word(input logic [1:0] op, input req_item_type w);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 30) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= op;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every reply has come and the sequencer has gone idle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_own(input logic [31:0] addr);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= addr;
      own_addr   = addr;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_word(output logic [1:0] op, output req_item_type w);
      int          sel;
      logic [15:0] opcode;
      logic [15:0] hw;
      logic [15:0] proto;
      logic [63:0] bits;
      logic [31:0] tip;
      bits   = {$urandom, $urandom};
      sel    = $urandom_range(0, 99);
      opcode = (sel < 45) ? OPCODE_REQUEST : (sel < 85) ? OPCODE_REPLY : bits[15:0];
      bits   = {$urandom, $urandom};
      hw     = ($urandom_range(0, 99) < 80) ? HW_ETHER : bits[15:0];
      proto  = ($urandom_range(0, 99) < 80) ? PTYPE_IP : bits[31:16];
      bits   = {$urandom, $urandom};
      sel    = $urandom_range(0, 99);
      if (sel < 50) op = OP_RX_PACKET;
      else if (sel < 85) op = OP_LOOKUP;
      else if (sel < 95) op = OP_REQ_SENT;
      else op = OP_UNUSED;
      // packets aim at us often so that replies and appends show up
      tip = (op == OP_RX_PACKET && $urandom_range(0, 99) < 40) ? own_addr : pick_ip();
      w = make_word(opcode, hw, proto, bits[47:0], pick_ip(), tip,
                    $urandom_range(0, 99) < 85);
   endtask

   initial begin
      logic [31:0]  dir_own;
      logic [31:0]  phase_own [PHASES];
      logic [1:0]   op;
      req_item_type w;

      ip_pool[0] = 32'h0000_0000;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
      dir_own   = $urandom;
      phase_own = '{32'h0000_0000, $urandom, 32'hFFFF_FFFF, $urandom, ip_pool[3]};

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed part
      write_own(dir_own);
      // unused operation code: all-zero reply
      send_word(OP_UNUSED, make_word('1, '1, '1, '1, '1, '1, 1'b1));
      // non-IPv4 packet is ignored
      send_word(OP_RX_PACKET, make_word(OPCODE_REQUEST, HW_ETHER, PROTO_IPV6,
                48'h0A0B_0C0D_0E0F, ip_pool[2], dir_own, 1'b1));
      // two pending entries for the same address
      send_word(OP_REQ_SENT, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h0, 32'h0, ip_pool[2], 1'b1));
      send_word(OP_REQ_SENT, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h0, 32'h0, ip_pool[2], 1'b1));
      // pending entry must not hit
      send_word(OP_LOOKUP, make_word(16'h0, 16'h0, 16'h0, 48'h0, 32'h0,
                ip_pool[2], 1'b1));
      // reply resolves the first pending entry
      send_word(OP_RX_PACKET, make_word(OPCODE_REPLY, HW_ETHER, PTYPE_IP,
                48'h1234_5678_9ABC, ip_pool[2], ~dir_own, 1'b0));
      send_word(OP_LOOKUP, make_word(16'h0, 16'h0, 16'h0, 48'h0, 32'h0,
                ip_pool[2], 1'b1));
      // non-Ethernet lookup never hits
      send_word(OP_LOOKUP, make_word(16'h0, 16'h0, 16'h0, 48'h0, 32'h0,
                ip_pool[2], 1'b0));
      // request for us from a new sender: append and answer
      send_word(OP_RX_PACKET, make_word(OPCODE_REQUEST, 16'hFFFF, PTYPE_IP,
                48'hFFFF_FFFF_FFFF, ip_pool[3], dir_own, 1'b0));
      // request for someone else from an unknown sender: nothing happens
      send_word(OP_RX_PACKET, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h0000_0000_0001, ip_pool[1], ~dir_own, 1'b1));
      // odd opcode appends but does not answer
      send_word(OP_RX_PACKET, make_word(16'hFFFF, 16'h0006, PTYPE_IP,
                48'h8000_0000_0000, ip_pool[4], dir_own, 1'b1));
      // all-zero sender, any hardware type
      send_word(OP_RX_PACKET, make_word(16'h0000, 16'h0000, PTYPE_IP,
                48'h0, ip_pool[0], dir_own, 1'b0));
      send_word(OP_LOOKUP, make_word(16'h0, 16'h0, 16'h0, 48'h0, 32'h0,
                ip_pool[0], 1'b1));
      // known requester asks again: update and answer
      send_word(OP_RX_PACKET, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h5555_AAAA_5555, ip_pool[3], dir_own, 1'b1));
      // fill the table with pending entries
      for (int i = 5; i < POOL_SIZE; i++) begin
         send_word(OP_REQ_SENT, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                   48'h0, 32'h0, ip_pool[i], 1'b1));
      end
      // full table: appends drop, a request for us is still answered
      send_word(OP_REQ_SENT, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h0, 32'h0, ip_pool[1], 1'b1));
      send_word(OP_RX_PACKET, make_word(OPCODE_REQUEST, HW_ETHER, PTYPE_IP,
                48'h0102_0304_0506, ip_pool[1], dir_own, 1'b1));

      // Random part, one own address per phase, phase 1 without idling
      for (int p = 0; p < PHASES; p++) begin
         write_own(phase_own[p]);
         quiet = (p == 1);
         for (int k = 0; k < RANDOM_WORDS / PHASES; k++) begin
            if (p == 0 && k == 120) drain();
            random_word(op, w);
            send_word(op, w);
         end
      end
      quiet = 1'b0;

      drain();
      if (errors == 0 && outstanding == 0)
         $display("tb_arp_cache_and_responder: done, clean");
      else
         $display("tb_arp_cache_and_responder: done, errors");
      $finish;
   end

endmodule
